FILE: rtl/ssr_pkg.sv
// Shared types and constants for the stream search-and-replace block.
// Used by ssr_front, ssr_fifo, ssr_back, the top level and the testbench.
// No dependencies.
package ssr_pkg;

    // Default sizes, handed down from the top level
    localparam int NEEDLE_MAX_DEF  = 8;
    localparam int REPLACE_MAX_DEF = 8;
    localparam int QUEUE_DEPTH_DEF = 4;

    // Configuration register indexes
    localparam int CFG_IDX_W = 4;
    localparam logic [CFG_IDX_W-1:0] REG_NEEDLE_BYTES      = 4'd0;
    localparam logic [CFG_IDX_W-1:0] REG_NEEDLE_LEN        = 4'd1;
    localparam logic [CFG_IDX_W-1:0] REG_REPLACEMENT_BYTES = 4'd2;
    localparam logic [CFG_IDX_W-1:0] REG_REPLACEMENT_LEN   = 4'd3;

    localparam logic [15:0] COUNT_MAX = 16'hFFFF;

    // Register file contents
    typedef struct packed {
        logic [63:0] needle_bytes;
        logic [3:0]  needle_len;
        logic [63:0] repl_bytes;
        logic [3:0]  repl_len;
    } cfg_t;

    // Command kinds passed from front to back
    typedef enum logic [1:0] {
        CMD_BYTE,
        CMD_REPL,
        CMD_EMPTY
    } cmd_kind_t;

    typedef struct packed {
        cmd_kind_t   kind;
        logic [7:0]  data;
        logic        last;
        logic [15:0] count;
    } cmd_t;

endpackage

FILE: rtl/ssr_front.sv
// Front end: accepts text bytes, keeps the partial-match window and turns
// each byte into byte / replacement / end commands for the back end.
// Depends on ssr_pkg.
module ssr_front #(
    parameter int NEEDLE_MAX = ssr_pkg::NEEDLE_MAX_DEF
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          s_tvalid,
    output logic          s_tready,
    input  logic [7:0]    in_byte,
    input  logic          final_byte,
    input  ssr_pkg::cfg_t cfg,
    input  logic          needle_wr,
    input  logic          q_full,
    output logic          q_push,
    output ssr_pkg::cmd_t q_cmd
);
    import ssr_pkg::*;

    localparam int CW = $clog2(NEEDLE_MAX + 1);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_STALE,
        ST_SCAN,
        ST_FLUSH,
        ST_END
    } state_t;

    state_t         state_reg;
    logic [7:0]     win_reg [NEEDLE_MAX];
    logic [CW-1:0]  cnt_reg;
    logic [7:0]     byte_reg;
    logic           fin_reg;
    logic           stale_reg;
    logic [15:0]    total_reg;
    logic           pend_valid_reg;
    cmd_t           pend_reg;

    logic [7:0]     ndl [NEEDLE_MAX];
    logic [CW-1:0]  n_lim;
    logic [7:0]     it_buf [NEEDLE_MAX];
    logic [7:0]     it_shift [NEEDLE_MAX];
    logic [CW-1:0]  it_cnt;
    logic [CW-1:0]  it_m;
    logic [CW-1:0]  it_sh;
    logic [CW-1:0]  it_cnt_after;
    logic           it_eq;
    logic           it_full;
    logic           it_part;
    logic           it_cmd_valid;
    cmd_t           it_cmd;
    logic           fin_cur;
    state_t         it_next_state;
    logic           accept;
    logic           go_stale;
    cmd_t           head_cmd;

    // Needle lanes and clamped length
    always_comb
    begin
        for (int i = 0; i < NEEDLE_MAX; i++)
        begin
            ndl[i] = cfg.needle_bytes[8*i +: 8];
        end
        if (cfg.needle_len > 4'(NEEDLE_MAX))
            n_lim = CW'(NEEDLE_MAX);
        else
            n_lim = cfg.needle_len[CW-1:0];
    end

    // One match step: on accept the new byte joins the window at cnt_reg
    always_comb
    begin
        for (int i = 0; i < NEEDLE_MAX; i++)
        begin
            it_buf[i] = win_reg[i];
            if (state_reg == ST_IDLE && CW'(i) == cnt_reg)
                it_buf[i] = in_byte;
        end
        it_cnt = (state_reg == ST_IDLE) ? cnt_reg + CW'(1) : cnt_reg;
        it_m   = (it_cnt < n_lim) ? it_cnt : n_lim;

        it_eq = 1'b1;
        for (int i = 0; i < NEEDLE_MAX; i++)
        begin
            if (CW'(i) < it_m && it_buf[i] != ndl[i])
                it_eq = 1'b0;
        end
        it_full = (n_lim != '0) && it_eq && (it_cnt >= n_lim);
        it_part = (n_lim != '0) && it_eq && !it_full;

        // Drop a whole needle on a match, keep a partial match, else release the oldest byte
        if (it_full)
            it_sh = n_lim;
        else if (it_part)
            it_sh = '0;
        else
            it_sh = CW'(1);
        it_cnt_after = it_cnt - it_sh;
        for (int i = 0; i < NEEDLE_MAX; i++)
        begin
            it_shift[i] = it_buf[i];
            for (int j = 0; j < NEEDLE_MAX; j++)
            begin
                if (j == i + int'(it_sh))
                    it_shift[i] = it_buf[j];
            end
        end

        it_cmd_valid = it_full ? (cfg.repl_len != 4'd0) : !it_part;
        it_cmd.kind  = it_full ? CMD_REPL : CMD_BYTE;
        it_cmd.data  = it_buf[0];
        it_cmd.last  = 1'b0;
        it_cmd.count = '0;

        fin_cur = (state_reg == ST_IDLE) ? final_byte : fin_reg;
        if (!it_part && it_cnt_after != '0)
            it_next_state = ST_SCAN;
        else if (fin_cur)
            it_next_state = (it_cnt_after != '0) ? ST_FLUSH : ST_END;
        else
            it_next_state = ST_IDLE;
    end

    // Handshake and queue push
    always_comb
    begin
        s_tready = (state_reg == ST_IDLE) && !q_full;
        accept   = s_tvalid && s_tready;
        go_stale = stale_reg && (cnt_reg != '0);

        head_cmd.kind  = CMD_BYTE;
        head_cmd.data  = win_reg[0];
        head_cmd.last  = 1'b0;
        head_cmd.count = '0;

        q_cmd = pend_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                q_push = pend_valid_reg && !q_full;
            end
            ST_STALE, ST_FLUSH:
            begin
                q_push = pend_valid_reg && !q_full;
            end
            ST_SCAN:
            begin
                q_push = pend_valid_reg && !q_full && it_cmd_valid;
            end
            ST_END:
            begin
                q_push = !q_full;
                if (pend_valid_reg)
                begin
                    q_cmd.last  = 1'b1;
                    q_cmd.count = total_reg;
                end
                else
                begin
                    q_cmd.kind  = CMD_EMPTY;
                    q_cmd.data  = '0;
                    q_cmd.last  = 1'b1;
                    q_cmd.count = total_reg;
                end
            end
            default:
            begin
                q_push = 1'b0;
            end
        endcase
    end

    // State and registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            cnt_reg        <= '0;
            stale_reg      <= 1'b0;
            total_reg      <= '0;
            pend_valid_reg <= 1'b0;
            fin_reg        <= 1'b0;
        end
        else
        begin
            if (needle_wr && cnt_reg != '0)
                stale_reg <= 1'b1;

            unique case (state_reg)
                ST_IDLE:
                begin
                    if (q_push)
                        pend_valid_reg <= 1'b0;
                    if (accept)
                    begin
                        byte_reg  <= in_byte;
                        fin_reg   <= final_byte;
                        stale_reg <= 1'b0;
                        if (go_stale)
                        begin
                            state_reg <= ST_STALE;
                        end
                        else
                        begin
                            for (int i = 0; i < NEEDLE_MAX; i++)
                            begin
                                win_reg[i] <= it_shift[i];
                            end
                            cnt_reg <= it_cnt_after;
                            if (it_cmd_valid)
                            begin
                                pend_reg       <= it_cmd;
                                pend_valid_reg <= 1'b1;
                            end
                            if (it_full && total_reg != COUNT_MAX)
                                total_reg <= total_reg + 16'd1;
                            state_reg <= it_next_state;
                        end
                    end
                end
                ST_STALE:
                begin
                    // Release held bytes from before the needle changed
                    if (!q_full)
                    begin
                        pend_reg       <= head_cmd;
                        pend_valid_reg <= 1'b1;
                        for (int i = 0; i < NEEDLE_MAX - 1; i++)
                        begin
                            win_reg[i] <= win_reg[i+1];
                        end
                        if (cnt_reg == CW'(1))
                        begin
                            win_reg[0] <= byte_reg;
                            state_reg  <= ST_SCAN;
                        end
                        else
                        begin
                            cnt_reg <= cnt_reg - CW'(1);
                        end
                    end
                end
                ST_SCAN:
                begin
                    if (!q_full)
                    begin
                        for (int i = 0; i < NEEDLE_MAX; i++)
                        begin
                            win_reg[i] <= it_shift[i];
                        end
                        cnt_reg <= it_cnt_after;
                        if (it_cmd_valid)
                        begin
                            pend_reg       <= it_cmd;
                            pend_valid_reg <= 1'b1;
                        end
                        if (it_full && total_reg != COUNT_MAX)
                            total_reg <= total_reg + 16'd1;
                        state_reg <= it_next_state;
                    end
                end
                ST_FLUSH:
                begin
                    // End of text: drain the window unchanged
                    if (!q_full)
                    begin
                        pend_reg       <= head_cmd;
                        pend_valid_reg <= 1'b1;
                        for (int i = 0; i < NEEDLE_MAX - 1; i++)
                        begin
                            win_reg[i] <= win_reg[i+1];
                        end
                        cnt_reg <= cnt_reg - CW'(1);
                        if (cnt_reg == CW'(1))
                            state_reg <= ST_END;
                    end
                end
                ST_END:
                begin
                    if (!q_full)
                    begin
                        pend_valid_reg <= 1'b0;
                        total_reg      <= '0;
                        state_reg      <= ST_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

endmodule

FILE: rtl/ssr_fifo.sv
// Short command queue between front and back end, show-ahead read.
// Depends on ssr_pkg (command type).
module ssr_fifo #(
    parameter int DEPTH = ssr_pkg::QUEUE_DEPTH_DEF
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          push,
    input  ssr_pkg::cmd_t push_data,
    output logic          full,
    input  logic          pop,
    output ssr_pkg::cmd_t pop_data,
    output logic          empty
);
    import ssr_pkg::*;

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int NW = $clog2(DEPTH + 1);

    cmd_t          slot_reg [DEPTH];
    logic [AW-1:0] wr_ptr_reg;
    logic [AW-1:0] rd_ptr_reg;
    logic [NW-1:0] fill_reg;

    assign full     = (fill_reg == NW'(DEPTH));
    assign empty    = (fill_reg == '0);
    assign pop_data = slot_reg[rd_ptr_reg];

    // Entry storage
    always_ff @(posedge clk)
    begin
        if (push && !full)
            slot_reg[wr_ptr_reg] <= push_data;
    end

    // Pointers and fill level
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            fill_reg   <= '0;
        end
        else
        begin
            if (push && !full)
                wr_ptr_reg <= (wr_ptr_reg == AW'(DEPTH - 1)) ? '0 : wr_ptr_reg + AW'(1);
            if (pop && !empty)
                rd_ptr_reg <= (rd_ptr_reg == AW'(DEPTH - 1)) ? '0 : rd_ptr_reg + AW'(1);
            if ((push && !full) && !(pop && !empty))
                fill_reg <= fill_reg + NW'(1);
            else if (!(push && !full) && (pop && !empty))
                fill_reg <= fill_reg - NW'(1);
        end
    end

endmodule

FILE: rtl/ssr_back.sv
// Back end: expands queued commands into result items, one per cycle while
// the receiver is ready, through a registered output stage. Depends on ssr_pkg.
module ssr_back #(
    parameter int REPLACE_MAX = ssr_pkg::REPLACE_MAX_DEF
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          q_empty,
    output logic          q_pop,
    input  ssr_pkg::cmd_t q_cmd,
    input  ssr_pkg::cfg_t cfg,
    output logic          m_tvalid,
    input  logic          m_tready,
    output logic [7:0]    out_byte,
    output logic          byte_valid,
    output logic          end_of_text,
    output logic [15:0]   replace_count
);
    import ssr_pkg::*;

    localparam int RW   = $clog2(REPLACE_MAX + 1);
    localparam int RI_W = (REPLACE_MAX > 1) ? $clog2(REPLACE_MAX) : 1;

    cmd_t            cur_reg;
    logic            cur_valid_reg;
    logic [RI_W-1:0] idx_reg;
    logic            out_valid_reg;
    logic [7:0]      out_byte_reg;
    logic            out_bv_reg;
    logic            out_last_reg;
    logic [15:0]     out_count_reg;

    logic [RW-1:0]   rl_lim;
    logic            rep_last;
    logic            item_done;
    logic            out_load;
    logic            step;
    logic [7:0]      item_byte;
    logic            item_bv;
    logic            item_last;

    // Current item from the command at the head
    always_comb
    begin
        if (cfg.repl_len > 4'(REPLACE_MAX))
            rl_lim = RW'(REPLACE_MAX);
        else
            rl_lim = cfg.repl_len[RW-1:0];
        rep_last = (RW'(idx_reg) == rl_lim - RW'(1));

        unique case (cur_reg.kind)
            CMD_BYTE:
            begin
                item_byte = cur_reg.data;
                item_bv   = 1'b1;
                item_done = 1'b1;
            end
            CMD_REPL:
            begin
                item_byte = cfg.repl_bytes[{idx_reg, 3'b000} +: 8];
                item_bv   = 1'b1;
                item_done = rep_last;
            end
            CMD_EMPTY:
            begin
                item_byte = '0;
                item_bv   = 1'b0;
                item_done = 1'b1;
            end
            default:
            begin
                item_byte = '0;
                item_bv   = 1'b0;
                item_done = 1'b1;
            end
        endcase
        item_last = cur_reg.last && item_done;

        out_load = !out_valid_reg || m_tready;
        step     = out_load && cur_valid_reg;
        q_pop    = !q_empty && (!cur_valid_reg || (step && item_done));
    end

    // Command register, replacement index and output stage
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cur_valid_reg <= 1'b0;
            out_valid_reg <= 1'b0;
            idx_reg       <= '0;
        end
        else
        begin
            if (out_load)
            begin
                out_valid_reg <= cur_valid_reg;
                out_byte_reg  <= item_byte;
                out_bv_reg    <= item_bv;
                out_last_reg  <= item_last;
                out_count_reg <= item_last ? cur_reg.count : 16'd0;
            end
            if (step)
                idx_reg <= item_done ? '0 : idx_reg + RI_W'(1);
            if (q_pop)
            begin
                cur_reg       <= q_cmd;
                cur_valid_reg <= 1'b1;
            end
            else if (step && item_done)
            begin
                cur_valid_reg <= 1'b0;
            end
        end
    end

    assign m_tvalid      = out_valid_reg;
    assign out_byte      = out_byte_reg;
    assign byte_valid    = out_bv_reg;
    assign end_of_text   = out_last_reg;
    assign replace_count = out_count_reg;

endmodule

FILE: rtl/stream_search_and_replace_top.sv
// Top level of the stream search-and-replace block: configuration
// registers, front end, command queue and back end.
// Depends on ssr_pkg, ssr_front, ssr_fifo, ssr_back.
//
// Usage:
//   Input stream (s_*): one text byte per transaction, s_tlast on the last
//   byte of a text. Output stream (m_*): one rewritten byte per transaction;
//   m_tlast marks the last item of a text, which also carries the count of
//   replacements (saturating at 65535). An item with byte_valid low is an
//   empty end marker for a text that produced no bytes in its last step.
//   Configuration (cfg_*): index 0 needle bytes, 1 needle length,
//   2 replacement bytes, 3 replacement length; write only while idle.
// Flow: the front end matches each accepted byte, then scans the window again
//   for each extra byte released or match found in the window, and on the
//   final byte flushes the window and sends the end item; the back end sends
//   one item per cycle while m_tready allows, and a match yields one item
//   per replacement byte.
// Reset clears the window, the count and the queue; registers read zero.
// When the receiver stalls, the output register holds its item, the queue
//   fills and s_tready drops; nothing is lost.
module stream_search_and_replace_top #(
    parameter int NEEDLE_MAX  = ssr_pkg::NEEDLE_MAX_DEF,
    parameter int REPLACE_MAX = ssr_pkg::REPLACE_MAX_DEF,
    parameter int QUEUE_DEPTH = ssr_pkg::QUEUE_DEPTH_DEF
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          s_tvalid,
    output logic                          s_tready,
    input  logic [7:0]                    s_tdata,   // [7:0] in_byte
    input  logic                          s_tlast,   // final_byte
    output logic                          m_tvalid,
    input  logic                          m_tready,
    output logic [23:0]                   m_tdata,   // [7:0] out_byte, [23:8] replace_count
    output logic [0:0]                    m_tuser,   // [0] byte_valid
    output logic                          m_tlast,   // end_of_text
    input  logic                          cfg_valid,
    output logic                          cfg_ready,
    input  logic [ssr_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [63:0]                   cfg_data
);
    import ssr_pkg::*;

    cfg_t        cfg_reg;
    logic        cfg_wr;
    logic        needle_wr;
    logic        q_push;
    cmd_t        q_push_cmd;
    logic        q_full;
    logic        q_pop;
    cmd_t        q_head;
    logic        q_empty;
    logic [7:0]  out_byte;
    logic        byte_valid;
    logic        end_of_text;
    logic [15:0] replace_count;

    // Configuration register file
    assign cfg_ready = 1'b1;
    assign cfg_wr    = cfg_valid && cfg_ready;
    assign needle_wr = cfg_wr && (cfg_index == REG_NEEDLE_BYTES ||
                                  cfg_index == REG_NEEDLE_LEN);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg <= '0;
        end
        else if (cfg_wr)
        begin
            unique case (cfg_index)
                REG_NEEDLE_BYTES:      cfg_reg.needle_bytes <= cfg_data;
                REG_NEEDLE_LEN:        cfg_reg.needle_len   <= cfg_data[3:0];
                REG_REPLACEMENT_BYTES: cfg_reg.repl_bytes   <= cfg_data;
                REG_REPLACEMENT_LEN:   cfg_reg.repl_len     <= cfg_data[3:0];
                default:               cfg_reg              <= cfg_reg;
            endcase
        end
    end

    ssr_front #(
        .NEEDLE_MAX (NEEDLE_MAX)
    ) u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .in_byte    (s_tdata),
        .final_byte (s_tlast),
        .cfg        (cfg_reg),
        .needle_wr  (needle_wr),
        .q_full     (q_full),
        .q_push     (q_push),
        .q_cmd      (q_push_cmd)
    );

    ssr_fifo #(
        .DEPTH (QUEUE_DEPTH)
    ) u_fifo (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (q_push),
        .push_data (q_push_cmd),
        .full      (q_full),
        .pop       (q_pop),
        .pop_data  (q_head),
        .empty     (q_empty)
    );

    ssr_back #(
        .REPLACE_MAX (REPLACE_MAX)
    ) u_back (
        .clk           (clk),
        .rst_n         (rst_n),
        .q_empty       (q_empty),
        .q_pop         (q_pop),
        .q_cmd         (q_head),
        .cfg           (cfg_reg),
        .m_tvalid      (m_tvalid),
        .m_tready      (m_tready),
        .out_byte      (out_byte),
        .byte_valid    (byte_valid),
        .end_of_text   (end_of_text),
        .replace_count (replace_count)
    );

    // Output packing
    assign m_tdata = {replace_count, out_byte};
    assign m_tuser = byte_valid;
    assign m_tlast = end_of_text;

endmodule

FILE: rtl/ssr_checker.sv
// Port-level checks for stream_search_and_replace_top, bound to the top.
// Depends on the top level's output stream ports only.
module ssr_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [23:0] m_tdata,
    input logic [0:0]  m_tuser,
    input logic        m_tlast
);
    // Stalled output transaction holds its contents
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) &&
                                  $stable(m_tuser) && $stable(m_tlast))
        else $error("output changed while stalled");

    // Empty marker only ends a text and carries a zero byte
    a_empty_marker: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tuser[0] |-> m_tlast && m_tdata[7:0] == 8'd0)
        else $error("empty marker malformed");

    // Count is reported only on the last item of a text
    a_count_on_last: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tlast |-> m_tdata[23:8] == 16'd0)
        else $error("count on non-final item");

    // No output during reset
    a_reset_quiet: assert property (@(posedge clk)
        !rst_n |-> !m_tvalid)
        else $error("output valid during reset");

endmodule

bind stream_search_and_replace_top ssr_checker u_ssr_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tuser   (m_tuser),
    .m_tlast   (m_tlast)
);

FILE: dv/tb.sv
`timescale 1ns / 100ps
// Testbench for stream_search_and_replace_top: directed texts from a table, then random
// texts, checked item by item against the table's expected items or a behavioral predictor.
// Depends on ssr_pkg and the block's RTL.
module tb;
    import ssr_pkg::*;

    localparam int WIN_MAX     = 8;        // needle bytes the window can hold
    localparam int REPL_MAX    = 8;
    localparam int STEP_CAP    = 16;       // most output items one input byte can cause
    localparam int SETTLE_CYC  = 24;       // quiet cycles before a register write
    localparam int HOLD_CYCLES = 300;      // long receiver hold-off
    localparam int RAND_ITEMS  = 500;
    localparam int CYCLE_LIMIT = 400_000;

    // One output transaction, field by field
    typedef struct packed {
        logic [7:0]  ch;
        logic        vld;
        logic        eot;
        logic [15:0] cnt;
    } out_item_t;

    typedef enum logic {ROW_CFG, ROW_CHAR} row_kind_t;

    typedef struct {
        row_kind_t             kind;
        logic [CFG_IDX_W-1:0]  idx;
        logic [63:0]           val;
        logic                  fin;
        bit                    typed;
        out_item_t             want;
    } dir_row_t;

    typedef enum logic [1:0] {RX_FREE, RX_COIN, RX_PERIODIC, RX_SLOW} rx_mode_t;

    logic                 clk = 1'b0;
    logic                 rst_n;
    logic                 s_tvalid;
    logic                 s_tready;
    logic [7:0]           s_tdata;
    logic                 s_tlast;
    logic                 m_tvalid;
    logic                 m_tready;
    logic [23:0]          m_tdata;
    logic [0:0]           m_tuser;
    logic                 m_tlast;
    logic                 cfg_valid;
    logic                 cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [63:0]          cfg_data;

    stream_search_and_replace_top u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tlast   (s_tlast),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .m_tlast   (m_tlast),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always #5 clk = ~clk;

    // Predictor copy of the registers and of the match window
    logic [63:0] needle_cfg     = '0;
    logic [3:0]  needle_len_cfg = '0;
    logic [63:0] repl_cfg       = '0;
    logic [3:0]  repl_len_cfg   = '0;
    logic [7:0]  win_bytes [WIN_MAX];
    int unsigned win_fill       = 0;
    logic [15:0] text_hits      = '0;
    bit          win_stale      = 1'b0;

    out_item_t   step_out[$];      // items caused by the byte just accepted
    out_item_t   pending_out[$];   // rewritten text still owed by the block
    dir_row_t    dir_rows[$];

    bit          tx_on       = 1'b0;
    int unsigned burst_left  = 0;
    bit          hold_req    = 1'b0;

    int unsigned n_chars = 0, n_texts = 0, n_cfg = 0, n_results = 0, n_errs = 0;
    int unsigned cycles  = 0;

    function automatic void emit_char(input logic [7:0] ch);
        if (step_out.size() < STEP_CAP)
            step_out.push_back('{ch: ch, vld: 1'b1, eot: 1'b0, cnt: 16'd0});
    endfunction

    // Search-and-replace step for one accepted byte; fills step_out
    function automatic void rewrite_byte(input logic [7:0] ch, input logic fin);
        logic [7:0]  work [WIN_MAX];
        int unsigned n, rl, c, m, i;
        bit          eq;
        out_item_t   tail;
        n  = (needle_len_cfg > WIN_MAX) ? WIN_MAX : needle_len_cfg;
        rl = (repl_len_cfg > REPL_MAX) ? REPL_MAX : repl_len_cfg;
        step_out.delete();
        if (win_fill > WIN_MAX - 1)
            win_fill = WIN_MAX - 1;
        // bytes held under an older needle leave untouched
        if (win_stale)
        begin
            for (i = 0; i < win_fill; i++)
                emit_char(win_bytes[i]);
            win_fill  = 0;
            win_stale = 1'b0;
        end
        for (i = 0; i < WIN_MAX; i++)
            work[i] = win_bytes[i];
        c = win_fill;
        work[c] = ch;
        c++;
        while (c > 0)
        begin
            eq = 1'b1;
            m  = (c < n) ? c : n;
            for (i = 0; i < m; i++)
                if (work[i] != needle_cfg[i*8 +: 8])
                    eq = 1'b0;
            if (n > 0 && eq && c >= n)
            begin
                for (i = 0; i < rl; i++)
                    emit_char(repl_cfg[i*8 +: 8]);
                if (text_hits != COUNT_MAX)
                    text_hits++;
                for (i = 0; i + n < c; i++)
                    work[i] = work[i + n];
                c -= n;
            end
            else if (n > 0 && eq)
                break;      // still a needle prefix: keep holding
            else
            begin
                emit_char(work[0]);
                for (i = 0; i + 1 < c; i++)
                    work[i] = work[i + 1];
                c--;
            end
        end
        // end of text: flush, then tag the last item with the count
        if (fin)
        begin
            for (i = 0; i < c; i++)
                emit_char(work[i]);
            c = 0;
            if (step_out.size() == 0)
                step_out.push_back('{ch: 8'h00, vld: 1'b0, eot: 1'b0, cnt: 16'd0});
            tail     = step_out.pop_back();
            tail.eot = 1'b1;
            tail.cnt = text_hits;
            step_out.push_back(tail);
            text_hits = '0;
        end
        for (i = 0; i < WIN_MAX; i++)
            win_bytes[i] = work[i];
        win_fill = c;
    endfunction

    function automatic void add_cfg(input logic [CFG_IDX_W-1:0] idx, input logic [63:0] val);
        dir_rows.push_back('{kind: ROW_CFG, idx: idx, val: val, fin: 1'b0, typed: 1'b0,
                             want: '0});
    endfunction

    function automatic void add_char(input logic [7:0] ch, input logic fin,
                                     input bit typed = 1'b0, input out_item_t want = '0);
        dir_rows.push_back('{kind: ROW_CHAR, idx: REG_NEEDLE_BYTES, val: {56'd0, ch}, fin: fin,
                             typed: typed, want: want});
    endfunction

    // Mostly a small alphabet so that needles and text collide often
    function automatic logic [7:0] pick_char();
        case ($urandom_range(0, 5))
            0: return 8'h00;
            1: return 8'hFF;
            2: return 8'h61;
            3: return 8'h62;
            default: return 8'($urandom);
        endcase
    endfunction

    task automatic cfg_write(input logic [CFG_IDX_W-1:0] idx, input logic [63:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        do @(posedge clk); while (cfg_ready !== 1'b1);
        cfg_valid <= 1'b0;
        @(posedge clk);
        n_cfg++;
        case (idx)
            REG_NEEDLE_BYTES:
            begin
                needle_cfg = val;
                if (win_fill > 0)
                    win_stale = 1'b1;
            end
            REG_NEEDLE_LEN:
            begin
                needle_len_cfg = val[3:0];
                if (win_fill > 0)
                    win_stale = 1'b1;
            end
            REG_REPLACEMENT_BYTES: repl_cfg     = val;
            REG_REPLACEMENT_LEN:   repl_len_cfg = val[3:0];
            default: ;
        endcase
    endtask

    // Stop sending, wait for every owed item, then let the front end settle
    task automatic drain_block();
        if (tx_on)
        begin
            s_tvalid <= 1'b0;
            tx_on = 1'b0;
        end
        while (pending_out.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYC) @(posedge clk);
    endtask

    // One input transaction; the sender runs in bursts with gaps between them
    task automatic send_char(input logic [7:0] ch, input logic fin,
                             input bit typed = 1'b0, input out_item_t want = '0);
        if (burst_left == 0)
        begin
            if (tx_on)
            begin
                s_tvalid <= 1'b0;
                tx_on = 1'b0;
            end
            repeat ($urandom_range(1, 6)) @(posedge clk);
            burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(40, 120)
                                                     : $urandom_range(1, 12);
        end
        s_tvalid <= 1'b1;
        tx_on = 1'b1;
        s_tdata <= ch;
        s_tlast <= fin;
        do @(posedge clk); while (s_tready !== 1'b1);
        burst_left--;
        rewrite_byte(ch, fin);
        if (typed)
            pending_out.push_back(want);
        else
            foreach (step_out[k])
                pending_out.push_back(step_out[k]);
        n_chars++;
        if (fin)
            n_texts++;
    endtask

    task automatic check_field(input string what, input logic [15:0] want,
                               input logic [15:0] got);
        if (want !== got)
        begin
            n_errs++;
            if (n_errs <= 40)
                $display("%0t: %s mismatch, expected %0h, got %0h", $time, what, want, got);
        end
    endtask

    // Output checker: every accepted transaction against the oldest expectation
    always @(posedge clk)
    begin : out_check
        out_item_t want;
        if (rst_n === 1'b1 && m_tvalid === 1'b1 && m_tready === 1'b1)
        begin
            n_results++;
            if (pending_out.size() == 0)
            begin
                n_errs++;
                $display("%0t: unexpected item, expected none, got data %h user %b last %b",
                         $time, m_tdata, m_tuser, m_tlast);
            end
            else
            begin
                want = pending_out.pop_front();
                check_field("out_byte", {8'd0, want.ch}, {8'd0, m_tdata[7:0]});
                check_field("byte_valid", {15'd0, want.vld}, {15'd0, m_tuser[0]});
                check_field("end_of_text", {15'd0, want.eot}, {15'd0, m_tlast});
                check_field("replace_count", want.cnt, m_tdata[23:8]);
            end
        end
    end

    // Receiver pacing: changing stall modes, plus a long hold-off on request
    initial
    begin : rx_pacing
        rx_mode_t    mode;
        int unsigned mode_left, hold_left, tick;
        mode      = RX_FREE;
        mode_left = 0;
        hold_left = 0;
        tick      = 0;
        m_tready <= 1'b0;
        forever
        begin
            @(posedge clk);
            tick++;
            if (hold_req)
            begin
                hold_req  = 1'b0;
                hold_left = HOLD_CYCLES;
            end
            if (mode_left == 0)
            begin
                mode      = rx_mode_t'($urandom_range(0, 3));
                mode_left = $urandom_range(20, 200);
            end
            mode_left--;
            if (hold_left > 0)
            begin
                hold_left--;
                m_tready <= 1'b0;
            end
            else
                case (mode)
                    RX_FREE:     m_tready <= 1'b1;
                    RX_COIN:     m_tready <= ($urandom_range(0, 1) == 1);
                    RX_PERIODIC: m_tready <= (tick % 5 != 0);
                    default:     m_tready <= ($urandom_range(0, 5) == 0);
                endcase
        end
    end

    // Watchdog
    always @(posedge clk)
    begin
        cycles++;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("** stream_search_and_replace_top: FAILED **");
            $finish;
        end
    end

    initial
    begin : stimulus
        logic [63:0]  val;
        logic [7:0]   piece[$];
        int unsigned  n_rand, phase_left, text_left, nl, lv, sel, k, j;
        bit           pressed;
        n_rand    = 0;
        text_left = 0;
        pressed   = 1'b0;

        s_tvalid  <= 1'b0;
        s_tdata   <= 8'h00;
        s_tlast   <= 1'b0;
        cfg_valid <= 1'b0;
        cfg_index <= REG_NEEDLE_BYTES;
        cfg_data  <= 64'd0;
        rst_n     <= 1'b0;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Registers read zero after reset: empty needle, bytes pass straight through
        add_char(8'h00, 1'b0, 1'b1, '{ch: 8'h00, vld: 1'b1, eot: 1'b0, cnt: 16'd0});
        add_char(8'hFF, 1'b1, 1'b1, '{ch: 8'hFF, vld: 1'b1, eot: 1'b1, cnt: 16'd0});
        // "ab" -> "XYZ": a match, a failed prefix that restarts, a short tail
        add_cfg(REG_NEEDLE_BYTES, 64'h6261);
        add_cfg(REG_NEEDLE_LEN, 64'd2);
        add_cfg(REG_REPLACEMENT_BYTES, 64'h5A5958);
        add_cfg(REG_REPLACEMENT_LEN, 64'd3);
        add_char(8'h61, 1'b0);
        add_char(8'h62, 1'b0);
        add_char(8'h61, 1'b0);
        add_char(8'h61, 1'b0);
        add_char(8'h62, 1'b0);
        add_char(8'h61, 1'b1);
        // Full needle of 00/FF, length above the maximum, deletion; the final byte
        // leaves nothing, so an empty end marker carries the count
        add_cfg(REG_NEEDLE_BYTES, 64'hFF00_FF00_FF00_FF00);
        add_cfg(REG_NEEDLE_LEN, 64'd15);
        add_cfg(REG_REPLACEMENT_LEN, 64'd0);
        for (int unsigned r = 0; r < 7; r++)
            add_char((r % 2 == 1) ? 8'hFF : 8'h00, 1'b0);
        add_char(8'hFF, 1'b1, 1'b1, '{ch: 8'h00, vld: 1'b0, eot: 1'b1, cnt: 16'd1});
        // One-byte needle, longest replacement of all ones
        add_cfg(REG_NEEDLE_BYTES, 64'h0);
        add_cfg(REG_NEEDLE_LEN, 64'd1);
        add_cfg(REG_REPLACEMENT_BYTES, 64'hFFFF_FFFF_FFFF_FFFF);
        add_cfg(REG_REPLACEMENT_LEN, 64'd8);
        add_char(8'h00, 1'b1);
        // Needle changed while a prefix is held: held bytes go out unchanged
        add_cfg(REG_NEEDLE_BYTES, 64'h636261);
        add_cfg(REG_NEEDLE_LEN, 64'd3);
        add_char(8'h61, 1'b0);
        add_char(8'h62, 1'b0);
        add_cfg(REG_NEEDLE_LEN, 64'd1);
        add_char(8'h63, 1'b0);
        add_char(8'h61, 1'b1);
        // Replacement length above the maximum
        add_cfg(REG_REPLACEMENT_LEN, 64'd15);
        add_char(8'h61, 1'b1);

        foreach (dir_rows[r])
        begin
            if (dir_rows[r].kind == ROW_CFG)
            begin
                drain_block();
                cfg_write(dir_rows[r].idx, dir_rows[r].val);
            end
            else
                send_char(dir_rows[r].val[7:0], dir_rows[r].fin, dir_rows[r].typed,
                          dir_rows[r].want);
        end

        // Random phases; a phase may end mid-text, so new needles also hit held bytes
        while (n_rand < RAND_ITEMS)
        begin
            drain_block();
            if ($urandom_range(0, 3) != 0)
            begin
                for (j = 0; j < 8; j++)
                    val[j*8 +: 8] = pick_char();
                cfg_write(REG_NEEDLE_BYTES, val);
            end
            if ($urandom_range(0, 3) != 0)
            begin
                lv = $urandom_range(0, 9);
                if (lv == 9)
                    lv = $urandom_range(9, 15);
                cfg_write(REG_NEEDLE_LEN, 64'(lv));
            end
            if ($urandom_range(0, 3) != 0)
                cfg_write(REG_REPLACEMENT_BYTES, {$urandom, $urandom});
            if ($urandom_range(0, 3) != 0)
                cfg_write(REG_REPLACEMENT_LEN, 64'($urandom_range(0, 15)));

            // once: receiver holds off while the sender keeps pushing
            if (!pressed && n_rand >= 150)
            begin
                pressed    = 1'b1;
                hold_req   = 1'b1;
                burst_left = 120;
            end

            phase_left = $urandom_range(25, 80);
            while (phase_left > 0 && n_rand < RAND_ITEMS)
            begin
                nl = (needle_len_cfg > WIN_MAX) ? WIN_MAX : needle_len_cfg;
                piece.delete();
                sel = $urandom_range(0, 9);
                if (sel < 5 && nl > 0)
                    for (j = 0; j < nl; j++)
                        piece.push_back(needle_cfg[j*8 +: 8]);
                else if (sel < 7 && nl > 1)
                begin
                    k = $urandom_range(1, nl - 1);
                    for (j = 0; j < k; j++)
                        piece.push_back(needle_cfg[j*8 +: 8]);
                end
                else if (sel < 9)
                    piece.push_back(pick_char());
                else
                    piece.push_back(8'($urandom));
                foreach (piece[p])
                begin
                    if (text_left == 0)
                        text_left = ($urandom_range(0, 7) == 0) ? 1 : $urandom_range(2, 40);
                    send_char(piece[p], text_left == 1);
                    text_left--;
                    n_rand++;
                    if (phase_left > 0)
                        phase_left--;
                end
            end
        end

        drain_block();
        $display("Sent %0d bytes in %0d texts with %0d register writes, random needles",
                 n_chars, n_texts, n_cfg);
        $display("and stalls; checked %0d output items against the predictor.", n_results);
        if (n_errs == 0)
            $display("** stream_search_and_replace_top: PASSED **");
        else
            $display("** stream_search_and_replace_top: FAILED **");
        $finish;
    end

endmodule
